FILE: rtl/core/dhr_pkg.sv
// Shared constants, types and helpers of the decimating history recorder.
`timescale 1ns / 1ps
`default_nettype none
package dhr_pkg;

	localparam int DEPTH     = 1024;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int SRC_W     = $clog2(DEPTH + 4);
	localparam int WORD_W    = 32;
	localparam int LIM_W     = 11;
	localparam int ENTRY_W   = 11;
	localparam int POW_W     = 5;
	localparam int RIDX_W    = 10;
	localparam int MAX_POWER = 16;
	localparam int STRIDE    = 4;

	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1024);

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t             op;
		logic [WORD_W-1:0]   a;
		logic [WORD_W-1:0]   b;
	} alu_req_t;

	typedef struct packed {
		logic [WORD_W-1:0]   sum;
		logic                carry;
	} alu_rsp_t;

	typedef struct packed {
		logic [WORD_W-1:0]   total;
		logic [WORD_W-1:0]   motion;
		logic [WORD_W-1:0]   field;
		logic [WORD_W-1:0]   stamp;
	} entry_t;

	typedef struct packed {
		logic                wr_en;
		logic [ADDR_W-1:0]   wr_addr;
		entry_t              wr_data;
		logic                rd_en;
		logic [ADDR_W-1:0]   rd_addr;
	} mem_req_t;

	typedef struct packed {
		logic                recorded;
		logic                combed;
		logic                index_valid;
		logic [ENTRY_W-1:0]  entry_count;
		logic [POW_W-1:0]    interval_exponent;
		entry_t              data;
	} result_t;

	// clamp the comb threshold to [4, DEPTH]
	function automatic logic [CNT_W-1:0] clamp_limit(logic [LIM_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (int'(v) < STRIDE) begin
			r = CNT_W'(STRIDE);
		end else if (int'(v) > DEPTH) begin
			r = CNT_W'(DEPTH);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/decimating_history_recorder_top.sv
// Top level of the decimating history recorder: ports, limit register, result register.
//
// channel  direction  handshake          contents
// s_*      in         s_tvalid/s_tready  sample offer or read request
// m_*      out        m_tvalid/m_tready  one result word per input word
// cfg_*    in         cfg_valid/cfg_ready capacity_limit
//
// A record word passes CHECK, SUM and DONE before ready returns; a read word RRD, RDAT (index
// in range only) and DONE. A comb steps CMP, CRD and CWR for each entry moved forward, then
// CEND; the shared adder steps the source index and compares it with the count.
// Reset clears count and interval exponent; store contents stay undefined.
// A finished result waits in the output register while the next word is taken;
// the sequencer holds its result only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module decimating_history_recorder_top
	import dhr_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// iteration, sample_time, field_energy, motion_energy, read_index, pad
	input  wire logic [143:0] s_tdata,
	// kind
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// entry_count, interval_exponent, out_time, out_field_energy,
	// out_motion_energy, out_total_energy
	output logic [143:0]      m_tdata,
	// recorded, combed, index_valid
	output logic [2:0]        m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [10:0]  cfg_data
);

	logic [LIM_W-1:0] limit_q;
	mem_req_t         mem_req;
	entry_t           mem_rd_data;
	logic             res_valid;
	logic             res_free;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	dhr_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	dhr_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.limit         (limit_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_kind       (s_tuser[0]),
		.in_iteration  (s_tdata[31:0]),
		.in_time       (s_tdata[63:32]),
		.in_field      (s_tdata[95:64]),
		.in_motion     (s_tdata[127:96]),
		.in_read_index (s_tdata[137:128]),
		.mem_req       (mem_req),
		.mem_rd_data   (mem_rd_data),
		.res_valid     (res_valid),
		.res_free      (res_free),
		.res           (res)
	);

	assign res_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	// load a new word only when the slot is free
	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.data.total, out_q.data.motion, out_q.data.field,
	                   out_q.data.stamp, out_q.interval_exponent, out_q.entry_count};
	assign m_tuser  = {out_q.index_valid, out_q.combed, out_q.recorded};

endmodule
`default_nettype wire

FILE: rtl/core/dhr_alu.sv
// Shared 32-bit add/subtract unit with carry out.
`timescale 1ns / 1ps
`default_nettype none
module dhr_alu
	import dhr_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [WORD_W:0] wide;

	always_comb begin
		unique case (req.op)
			ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
			ALU_SUB: wide = {1'b0, req.a} + {1'b0, ~req.b} + (WORD_W+1)'(1);
			default: wide = '0;
		endcase
	end

	// for subtract, carry set means a >= b
	assign rsp.sum   = wide[WORD_W-1:0];
	assign rsp.carry = wide[WORD_W];

endmodule
`default_nettype wire

FILE: rtl/core/dhr_store.sv
// History store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module dhr_store
	import dhr_pkg::*;
(
	input  wire logic clk,
	input  mem_req_t  req,
	output entry_t    rd_data
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: rtl/core/dhr_seq.sv
// Sequencer: record, comb and read steps around the shared adder.
`timescale 1ns / 1ps
`default_nettype none
module dhr_seq
	import dhr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [LIM_W-1:0]     limit,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_kind,
	input  wire logic [WORD_W-1:0]    in_iteration,
	input  wire logic [WORD_W-1:0]    in_time,
	input  wire logic [WORD_W-1:0]    in_field,
	input  wire logic [WORD_W-1:0]    in_motion,
	input  wire logic [RIDX_W-1:0]    in_read_index,
	output mem_req_t                  mem_req,
	input  entry_t                    mem_rd_data,
	output logic                      res_valid,
	input  wire logic                 res_free,
	output result_t                   res
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_CHECK = 10'b0000000010,
		ST_CMP   = 10'b0000000100,
		ST_CRD   = 10'b0000001000,
		ST_CWR   = 10'b0000010000,
		ST_CEND  = 10'b0000100000,
		ST_SUM   = 10'b0001000000,
		ST_RRD   = 10'b0010000000,
		ST_RDAT  = 10'b0100000000,
		ST_DONE  = 10'b1000000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [POW_W-1:0]   power_q;
	logic [SRC_W-1:0]   src_q;
	logic [ADDR_W-1:0]  dst_q;
	logic               kind_q;
	logic [WORD_W-1:0]  iter_q;
	logic [WORD_W-1:0]  time_q;
	logic [WORD_W-1:0]  field_q;
	logic [WORD_W-1:0]  motion_q;
	logic [RIDX_W-1:0]  ridx_q;
	logic               rec_q;
	logic               comb_q;
	logic               ivld_q;
	entry_t             data_q;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic [WORD_W-1:0]  iter_mask;
	logic [WORD_W-1:0]  total;
	logic               take;
	logic               ridx_ok;
	logic               accept;

	dhr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign iter_mask = ~({WORD_W{1'b1}} << {power_q, 1'b0});
	assign total     = alu_rsp.carry ? {WORD_W{1'b1}} : alu_rsp.sum;
	assign take      = ((iter_q & iter_mask) == '0) && (count_q < CNT_W'(DEPTH));
	assign ridx_ok   = (32'(ridx_q) < 32'(count_q)) && (32'(ridx_q) < DEPTH);

	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = field_q;
		alu_req.b  = motion_q;
		if (state_q == ST_CMP) begin
			alu_req.op = ALU_SUB;
			alu_req.a  = 32'(src_q);
			alu_req.b  = 32'(count_q);
		end else if (state_q == ST_CRD) begin
			alu_req.a  = 32'(src_q);
			alu_req.b  = 32'(STRIDE);
		end
	end

	always_comb begin
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = dst_q;
		mem_req.wr_data = mem_rd_data;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = ADDR_W'(src_q);
		unique case (state_q)
			ST_CRD:  mem_req.rd_en = 1'b1;
			ST_CWR:  mem_req.wr_en = 1'b1;
			ST_SUM: begin
				mem_req.wr_en   = take;
				mem_req.wr_addr = ADDR_W'(count_q);
				mem_req.wr_data = '{total: total, motion: motion_q,
				                    field: field_q, stamp: time_q};
			end
			ST_RRD: begin
				mem_req.rd_en   = ridx_ok;
				mem_req.rd_addr = ADDR_W'(ridx_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			power_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= in_kind ? ST_RRD : ST_CHECK;
				ST_CHECK: state_q <= (count_q >= clamp_limit(limit)) ? ST_CMP : ST_SUM;
				ST_CMP:  state_q <= alu_rsp.carry ? ST_CEND : ST_CRD;
				ST_CRD:  state_q <= ST_CWR;
				ST_CWR:  state_q <= ST_CMP;
				ST_CEND: begin
					count_q <= count_q >> 2;
					if (int'(power_q) < MAX_POWER) begin
						power_q <= power_q + POW_W'(1);
					end
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (take) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_RRD:  state_q <= ridx_ok ? ST_RDAT : ST_DONE;
				ST_RDAT: state_q <= ST_DONE;
				ST_DONE: if (res_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and per-item flags
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= in_kind;
			iter_q   <= in_iteration;
			time_q   <= in_time;
			field_q  <= in_field;
			motion_q <= in_motion;
			ridx_q   <= in_read_index;
			rec_q    <= 1'b0;
			comb_q   <= 1'b0;
			ivld_q   <= 1'b0;
			data_q   <= '0;
		end
		unique case (state_q)
			ST_CHECK: begin
				src_q <= SRC_W'(STRIDE);
				dst_q <= ADDR_W'(1);
			end
			ST_CRD:  src_q <= SRC_W'(alu_rsp.sum);
			ST_CWR:  dst_q <= dst_q + ADDR_W'(1);
			ST_CEND: comb_q <= 1'b1;
			ST_SUM:  rec_q <= take;
			ST_RRD:  ivld_q <= ridx_ok;
			ST_RDAT: data_q <= mem_rd_data;
			default: ;
		endcase
	end

	assign res_valid             = (state_q == ST_DONE);
	assign res.recorded          = rec_q && !kind_q;
	assign res.combed            = comb_q;
	assign res.index_valid       = ivld_q;
	assign res.entry_count       = ENTRY_W'(count_q);
	assign res.interval_exponent = power_q;
	assign res.data              = data_q;

endmodule
`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench of the decimating history recorder, with its own history model.
`timescale 1ns / 1ps
module tb;
	import dhr_pkg::*;

	localparam int STALL_LIMIT = 6000;
	localparam int SHOW_LIMIT  = 40;
	localparam int N_PHASES    = 7;

	typedef enum logic {
		KIND_RECORD = 1'b0,
		KIND_READ   = 1'b1
	} item_kind_t;

	typedef struct {
		bit                recorded;
		bit                combed;
		bit                index_valid;
		bit [ENTRY_W-1:0]  entry_count;
		bit [POW_W-1:0]    exponent;
		bit [WORD_W-1:0]   stamp;
		bit [WORD_W-1:0]   field;
		bit [WORD_W-1:0]   motion;
		bit [WORD_W-1:0]   total;
	} history_result_t;

	class history_scoreboard;
		bit [WORD_W-1:0]  stamp_mem[DEPTH];
		bit [WORD_W-1:0]  field_mem[DEPTH];
		bit [WORD_W-1:0]  motion_mem[DEPTH];
		bit [WORD_W-1:0]  total_mem[DEPTH];
		int unsigned      count;
		int unsigned      power;
		int unsigned      high_water;
		bit [LIM_W-1:0]   limit = LIMIT_RESET;
		history_result_t  expected_results[$];
		int unsigned      errors;
		int unsigned      n_words, n_stored, n_combs, n_valid_reads, n_stale_reads, n_saturated;

		function void set_limit(logic [LIM_W-1:0] v);
			limit = v;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function int unsigned comb_threshold();
			if (limit < STRIDE) return STRIDE;
			if (limit > DEPTH) return DEPTH;
			return limit;
		endfunction

		// keep every fourth entry, compacted towards the front
		function void comb_history();
			int unsigned dst;
			int unsigned src;
			dst = 1;
			for (src = STRIDE; src < count && src < DEPTH; src += STRIDE) begin
				stamp_mem[dst]  = stamp_mem[src];
				field_mem[dst]  = field_mem[src];
				motion_mem[dst] = motion_mem[src];
				total_mem[dst]  = total_mem[src];
				dst++;
			end
			if (power < MAX_POWER) power++;
			count = count / STRIDE;
		endfunction

		function void note_item(item_kind_t kind, logic [143:0] d);
			history_result_t r;
			logic [31:0] iter, stamp, fe, me;
			logic [9:0]  idx;
			logic [63:0] mask;
			logic [32:0] sum;
			r = '{default: '0};
			iter  = d[31:0];
			stamp = d[63:32];
			fe    = d[95:64];
			me    = d[127:96];
			idx   = d[137:128];
			n_words++;
			if (kind == KIND_RECORD) begin
				if (count >= comb_threshold()) begin
					comb_history();
					r.combed = 1'b1;
					n_combs++;
				end
				mask = (64'd1 << (2 * power)) - 64'd1;
				if (({32'd0, iter} & mask) == 64'd0 && count < DEPTH) begin
					sum = {1'b0, fe} + {1'b0, me};
					stamp_mem[count]  = stamp;
					field_mem[count]  = fe;
					motion_mem[count] = me;
					total_mem[count]  = sum[32] ? '1 : sum[31:0];
					if (sum[32]) n_saturated++;
					count++;
					if (count > high_water) high_water = count;
					r.recorded = 1'b1;
					n_stored++;
				end
			end else if (idx < count) begin
				r.stamp       = stamp_mem[idx];
				r.field       = field_mem[idx];
				r.motion      = motion_mem[idx];
				r.total       = total_mem[idx];
				r.index_valid = 1'b1;
				n_valid_reads++;
			end else begin
				n_stale_reads++;
			end
			r.entry_count = count[ENTRY_W-1:0];
			r.exponent    = power[POW_W-1:0];
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void compare(string what, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= SHOW_LIMIT)
					$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
						$time, what, want, got);
			end
		endfunction

		function void check_result(logic [2:0] u, logic [143:0] d);
			history_result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected, expected none, actual 0x%0h",
					$time, d);
				return;
			end
			e = expected_results.pop_front();
			compare("recorded", 32'(e.recorded), 32'(u[0]));
			compare("combed", 32'(e.combed), 32'(u[1]));
			compare("index_valid", 32'(e.index_valid), 32'(u[2]));
			compare("entry_count", 32'(e.entry_count), 32'(d[10:0]));
			compare("interval_exponent", 32'(e.exponent), 32'(d[15:11]));
			compare("out_time", e.stamp, d[47:16]);
			compare("out_field_energy", e.field, d[79:48]);
			compare("out_motion_energy", e.motion, d[111:80]);
			compare("out_total_energy", e.total, d[143:112]);
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [143:0]  s_tdata = '0;
	logic [0:0]    s_tuser = '0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [143:0]  m_tdata;
	logic [2:0]    m_tuser;
	logic          cfg_valid = 1'b0;
	logic          cfg_ready;
	logic [10:0]   cfg_data = '0;

	history_scoreboard sb = new();
	bit            steady_flow;
	bit            hold_armed = 1'b1;
	int unsigned   results_seen;
	int unsigned   quiet_cycles;

	decimating_history_recorder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [143:0] pack_item(logic [31:0] iter, logic [31:0] stamp,
			logic [31:0] fe, logic [31:0] me, logic [9:0] idx);
		return {6'd0, idx, me, fe, stamp, iter};
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (steady_flow || r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance, later if a random idle gap follows
	task automatic offer_word(item_kind_t kind, logic [143:0] data);
		int gap;
		s_tuser  = kind;
		s_tdata  = data;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// drop valid and wait for every outstanding result to drain
	task automatic drain();
		s_tvalid = 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_limit(logic [10:0] v);
		cfg_data  = v;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly samples on the current interval grid, some off-grid noise; the rest are reads
	task automatic random_item(int rec_pct);
		item_kind_t  kind;
		logic [31:0] iter, fe, me;
		logic [9:0]  idx;
		logic [63:0] k;
		int unsigned cnt, hw;
		cnt  = sb.count;
		hw   = sb.high_water;
		kind = (hw == 0 || $urandom_range(99) < rec_pct) ? KIND_RECORD : KIND_READ;
		k    = {$urandom, $urandom};
		iter = ($urandom_range(99) < rec_pct) ? 32'(k << (2 * sb.power)) : $urandom;
		fe   = $urandom;
		me   = $urandom;
		if ($urandom_range(9) == 0) begin
			fe[31:28] = '1;
			me[31:28] = '1;
		end
		if (kind == KIND_RECORD)
			idx = 10'($urandom);
		else if (cnt > 0 && ($urandom_range(99) < 85 || hw <= cnt))
			idx = 10'($urandom_range(cnt - 1, 0));
		else
			idx = 10'($urandom_range(hw - 1, cnt));
		offer_word(kind, pack_item(iter, $urandom, fe, me, idx));
	endtask

	// result side: random back-pressure plus one long hold-off
	initial begin
		int stall;
		int r;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_armed && results_seen >= 300) begin
				hold_armed = 1'b0;
				m_tready   = 1'b0;
				repeat (400) @(negedge clk);
			end else if (stall > 0) begin
				m_tready = 1'b0;
				stall--;
			end else begin
				r = $urandom_range(99);
				if (steady_flow || r < 70) begin
					m_tready = 1'b1;
				end else begin
					m_tready = 1'b0;
					stall = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
				end
			end
		end
	end

	// sample all three channels at the rising edge; watch for a hang
	always @(posedge clk) begin
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_item(item_kind_t'(s_tuser[0]), s_tdata);
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata);
				results_seen++;
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_limit(cfg_data);
				moved = 1'b1;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase_limit[N_PHASES] = '{1024, 2047, 37, 1025, 7, 5, 0};
		int phase_items[N_PHASES] = '{1250, 100, 180, 60, 130, 90, 130};
		int phase_rec[N_PHASES]   = '{95, 80, 85, 75, 85, 80, 85};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// tiny limit so that combs and interval growth show up early
		steady_flow = 1'b0;
		write_limit(11'd4);
		offer_word(KIND_RECORD, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd0));
		offer_word(KIND_RECORD, pack_item('1, '1, '1, '1, '1));
		offer_word(KIND_RECORD, pack_item(32'd2, 32'h0001_8000, '1, 32'd1, 10'd0));
		offer_word(KIND_RECORD, pack_item(32'd3, 32'h0002_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 10'd0));
		offer_word(KIND_READ, pack_item('1, '1, '1, '1, 10'd0));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd1));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd3));
		// limit reached: comb, then iteration 4 lands on the new grid
		offer_word(KIND_RECORD, pack_item(32'd4, 32'h0004_0000, 32'd7, 32'd9, 10'd0));
		offer_word(KIND_RECORD, pack_item(32'd5, 32'h0005_0000, 32'd1, 32'd1, 10'd0));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd1));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd3));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd2));
		offer_word(KIND_RECORD, pack_item(32'd8, 32'h0008_0000, 32'd3, 32'd4, 10'd0));
		offer_word(KIND_RECORD, pack_item(32'd12, 32'h000C_0000, 32'd5, 32'd6, 10'd0));
		// comb fires but iteration 13 falls off the grid
		offer_word(KIND_RECORD, pack_item(32'd13, 32'h000D_0000, 32'd8, 32'd8, 10'd0));
		offer_word(KIND_RECORD, pack_item(32'd16, 32'h0010_0000, '1, '1, 10'd0));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd1));
		offer_word(KIND_READ, pack_item(32'd0, 32'd0, 32'd0, 32'd0, 10'd0));
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			steady_flow = (p == 3) || ($urandom_range(3) == 0);
			write_limit(11'(phase_limit[p]));
			for (int n = 0; n < phase_items[p]; n++) begin
				if (p == 0 && n == 700) drain();
				random_item(phase_rec[p]);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d words: %0d samples stored, %0d combs, %0d saturated totals",
			sb.n_words, sb.n_stored, sb.n_combs, sb.n_saturated);
		$display("Reads: %0d in range, %0d past the count; final exponent %0d, %0d entries",
			sb.n_valid_reads, sb.n_stale_reads, sb.power, sb.count);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
